### hw/rtl/mctt_pkg.sv
// Shared types and constants for the tick timer table.
package mctt_pkg;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned DELAY_W  = 31;
  localparam int unsigned BASE_W   = 20;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [BASE_W-1:0] BASE_MIN   = 20'd10;
  localparam logic [BASE_W-1:0] BASE_RESET = 20'd10;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_REG   = 2'd1,
    CMD_UNREG = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [HANDLE_W-1:0]       handle;
    logic signed [COUNT_W-1:0] count;
    logic signed [COUNT_W-1:0] reload;
    logic                      periodic;
    logic                      notify;
    logic [TAG_W-1:0]          tag;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

### hw/rtl/mctt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mctt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/multi_channel_tick_timer_table.sv
// Top level of the tick timer table: command sequencer around the slot RAM.
//
// Input words carry one command each: a tick, a timer registration or a
// timer removal. The command code travels in in_tuser, its operands in
// in_tdata. Every accepted word yields exactly one result word on the out_
// channel (status, new handle, firing report). The user must write the time
// base register via cfg_wen/cfg_wdata only while the block is idle (unchecked).
//
// One command is in work at a time; in_tready is high only when idle.
// A tick walks the slot RAM with one read per cycle and writes each slot
// back in the cycle after its read. A removal walks the same way and stops
// at the first match. A registration runs a 31-step restoring divider and
// then scans the valid bits for the lowest free slot. An unused command
// goes straight to its result word.
//
// Reset clears the valid bits (all slots free), sets the handle counter to
// one and the time base to 10. A result waits in the output register while
// the receiver stalls; the block holds its finished result until then.
module multi_channel_tick_timer_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [30:0] delay_us, [31] periodic, [32] notify, [64:33] user_tag,
  // [80:65] target_handle, zero fill above
  input  logic [mctt_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] command
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [17:2] new_handle, [18] fired, [50:19] fired_tag,
  // [66:51] fired_handle, zero fill above
  output logic [mctt_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_wen,
  input  logic [mctt_pkg::BASE_W-1:0]       cfg_wdata
);

  import mctt_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1) + 1;
  localparam logic [CW-1:0] LAST = CW'(ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_TICK  = 6'b001000,
    S_UNREG = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [BASE_W-1:0]   base_r;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [HANDLE_W-1:0] hcnt_r, hcnt_nxt;

  // Captured command operands.
  logic                per_r, ntf_r;
  logic [TAG_W-1:0]    tag_r;
  logic [HANDLE_W-1:0] target_r;
  logic [BASE_W-1:0]   dbase_r;

  // Divider.
  logic [DELAY_W-1:0]  quo_r, quo_nxt;
  logic [BASE_W-1:0]   rem_r, rem_nxt;
  logic [4:0]          step_r, step_nxt;

  // RAM walk.
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pidx_r, pidx_nxt;
  logic                done_r, done_nxt;

  // Result in work and output register.
  logic [1:0]          rs_status_r, rs_status_nxt;
  logic [HANDLE_W-1:0] rs_nh_r, rs_nh_nxt;
  logic                rs_fired_r, rs_fired_nxt;
  logic [TAG_W-1:0]    rs_ftag_r, rs_ftag_nxt;
  logic [HANDLE_W-1:0] rs_fh_r, rs_fh_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  slot_t             ram_wdata, ram_rdata;

  logic [BASE_W-1:0]   in_base;
  logic [DELAY_W-1:0]  in_delay;
  logic [BASE_W:0]     trial;
  logic [23:0]         rem10, base6;
  logic [COUNT_W-1:0]  cnt_val;
  logic signed [COUNT_W-1:0] dec;
  logic                in_acc;

  mctt_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_base  = (base_r < BASE_MIN) ? BASE_MIN : base_r;
  assign in_delay = in_tdata[30:0];

  assign trial = {rem_r, quo_r[DELAY_W-1]};
  assign rem10 = {1'b0, rem_r, 3'b000} + {3'b000, rem_r, 1'b0};
  assign base6 = {2'b00, dbase_r, 2'b00} + {3'b000, dbase_r, 1'b0};
  // Round up when the tenths digit of the remainder is above five.
  assign cnt_val = {1'b0, quo_r} + {{(COUNT_W-1){1'b0}}, (rem10 >= base6)};
  assign dec = (ram_rdata.count == {1'b1, {(COUNT_W-1){1'b0}}}) ?
               ram_rdata.count : ram_rdata.count - 1;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    hcnt_nxt      = hcnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    done_nxt      = done_r;
    rs_status_nxt = rs_status_r;
    rs_nh_nxt     = rs_nh_r;
    rs_fired_nxt  = rs_fired_r;
    rs_ftag_nxt   = rs_ftag_r;
    rs_fh_nxt     = rs_fh_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = pidx_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rs_status_nxt = ST_OK;
          rs_nh_nxt     = '0;
          rs_fired_nxt  = 1'b0;
          rs_ftag_nxt   = '0;
          rs_fh_nxt     = '0;
          idx_nxt       = '0;
          done_nxt      = 1'b0;
          unique case (cmd_t'(in_tuser))
            CMD_TICK: state_nxt = S_TICK;
            CMD_REG: begin
              quo_nxt   = (in_delay < DELAY_W'(in_base)) ? DELAY_W'(in_base) : in_delay;
              rem_nxt   = '0;
              step_nxt  = '0;
              state_nxt = S_DIV;
            end
            CMD_UNREG: begin
              rs_status_nxt = ST_NOT_FOUND;
              state_nxt     = S_UNREG;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, dbase_r}) begin
          rem_nxt = BASE_W'(trial - {1'b0, dbase_r});
          quo_nxt = {quo_r[DELAY_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[BASE_W-1:0];
          quo_nxt = {quo_r[DELAY_W-2:0], 1'b0};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(DELAY_W - 1)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == LAST) begin
          rs_status_nxt = ST_FULL;
          state_nxt     = S_DONE;
        end else if (!valid_r[idx_r[AW-1:0]]) begin
          ram_we           = 1'b1;
          ram_waddr        = idx_r[AW-1:0];
          ram_wdata.handle = hcnt_r;
          ram_wdata.count  = cnt_val;
          ram_wdata.reload = cnt_val;
          ram_wdata.periodic = per_r;
          ram_wdata.notify = ntf_r;
          ram_wdata.tag    = tag_r;
          valid_nxt[idx_r[AW-1:0]] = 1'b1;
          rs_nh_nxt = hcnt_r;
          hcnt_nxt  = (hcnt_r + 1'b1 == '0) ? HANDLE_W'(1) : hcnt_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TICK: begin
        // Reads run one slot ahead of the write-back, so they never collide.
        if (idx_r != LAST) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
          idx_nxt  = idx_r + 1'b1;
        end
        if (pend_r && valid_r[pidx_r]) begin
          ram_we          = 1'b1;
          ram_wdata.count = dec;
          if (!done_r && dec[COUNT_W-1] && ram_rdata.notify) begin
            done_nxt     = 1'b1;
            rs_fired_nxt = 1'b1;
            rs_ftag_nxt  = ram_rdata.tag;
            rs_fh_nxt    = ram_rdata.handle;
            if (ram_rdata.periodic) begin
              ram_wdata.count = ram_rdata.reload;
            end else begin
              ram_we            = 1'b0;
              valid_nxt[pidx_r] = 1'b0;
            end
          end
        end
        if (idx_r == LAST && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_UNREG: begin
        if (idx_r != LAST) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
          idx_nxt  = idx_r + 1'b1;
        end
        if (pend_r && valid_r[pidx_r] && target_r != '0 &&
            ram_rdata.handle == target_r) begin
          valid_nxt[pidx_r] = 1'b0;
          rs_status_nxt     = ST_OK;
          pend_nxt          = 1'b0;
          state_nxt         = S_DONE;
        end else if (idx_r == LAST && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, rs_fh_r, rs_ftag_r, rs_fired_r, rs_nh_r, rs_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= BASE_RESET;
      valid_r     <= '0;
      hcnt_r      <= HANDLE_W'(1);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      done_r      <= 1'b0;
      idx_r       <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      hcnt_r      <= hcnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      done_r      <= done_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      if (cfg_wen) begin
        base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      per_r    <= in_tdata[31];
      ntf_r    <= in_tdata[32];
      tag_r    <= in_tdata[64:33];
      target_r <= in_tdata[80:65];
      dbase_r  <= in_base;
    end
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    pidx_r      <= pidx_nxt;
    rs_status_r <= rs_status_nxt;
    rs_nh_r     <= rs_nh_nxt;
    rs_fired_r  <= rs_fired_nxt;
    rs_ftag_r   <= rs_ftag_nxt;
    rs_fh_r     <= rs_fh_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

### hw/rtl/mctt_chk.sv
// Port-level checks for the tick timer table, bound to the top level.
module mctt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while a command is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("unused status code");

  a_no_fire_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[18] |-> out_tdata[66:19] == '0)
    else $error("firing fields set without a firing");

  a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[17:2] == '0)
    else $error("handle given on a failed command");

endmodule

bind multi_channel_tick_timer_table mctt_chk u_mctt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/sv/multi_channel_tick_timer_table_test.sv
// Self-checking stream testbench for the tick timer table with its own timer model.
module multi_channel_tick_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mctt_pkg::*;

  localparam int SLOTS = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = CMD_TICK;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_wen = 1'b0;
  logic [BASE_W-1:0] cfg_wdata = '0;

  typedef struct {
    cmd_t cmd;
    logic [DELAY_W-1:0] delay;
    logic periodic;
    logic notify;
    logic [TAG_W-1:0] tag;
    logic [HANDLE_W-1:0] target;
  } command_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [HANDLE_W-1:0] new_handle;
    logic fired;
    logic [TAG_W-1:0] fired_tag;
    logic [HANDLE_W-1:0] fired_handle;
  } reply_word_t;

  typedef struct {
    command_word_t cw;
    bit known;
    reply_word_t want;
  } stim_row_t;

  // Model state of the timer table.
  logic [HANDLE_W-1:0] m_handle[SLOTS];
  logic signed [COUNT_W-1:0] m_count[SLOTS];
  logic signed [COUNT_W-1:0] m_reload[SLOTS];
  logic m_periodic[SLOTS];
  logic m_notify[SLOTS];
  logic [TAG_W-1:0] m_tag[SLOTS];
  logic [HANDLE_W-1:0] m_next_handle;
  logic [BASE_W-1:0] m_base;

  reply_word_t expected_replies[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;

  multi_channel_tick_timer_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #400ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void clear_slot(int k);
    m_handle[k] = '0;
    m_count[k] = -1;
    m_reload[k] = -1;
    m_periodic[k] = 1'b0;
    m_notify[k] = 1'b0;
    m_tag[k] = '0;
  endfunction

  function automatic void model_reset();
    for (int k = 0; k < SLOTS; k++) clear_slot(k);
    m_next_handle = 16'd1;
    m_base = BASE_RESET;
  endfunction

  function automatic reply_word_t timer_table_step(command_word_t cw);
    reply_word_t r;
    bit done;
    int k;
    logic [31:0] base, d, cnt, rem;
    logic [63:0] frac;
    r = '{default: '0};
    case (cw.cmd)
      CMD_TICK: begin
        done = 1'b0;
        for (k = 0; k < SLOTS; k++) begin
          if (m_handle[k] != 0) begin
            if (m_count[k] != 32'sh8000_0000) m_count[k] = m_count[k] - 1;
            if (!done && m_count[k] < 0 && m_notify[k]) begin
              done = 1'b1;
              r.fired = 1'b1;
              r.fired_tag = m_tag[k];
              r.fired_handle = m_handle[k];
              if (m_periodic[k]) m_count[k] = m_reload[k];
              else clear_slot(k);
            end
          end
        end
      end
      CMD_REG: begin
        base = (m_base < BASE_MIN) ? 32'(BASE_MIN) : 32'(m_base);
        d = (32'(cw.delay) < base) ? base : 32'(cw.delay);
        cnt = d / base;
        rem = d % base;
        frac = (64'(rem) * 10) / base;
        if (frac > 5) cnt++;
        for (k = 0; k < SLOTS; k++) if (m_handle[k] == 0) break;
        if (k == SLOTS) begin
          r.status = ST_FULL;
        end else begin
          m_handle[k] = (m_next_handle == 0) ? 16'd1 : m_next_handle;
          m_next_handle = m_handle[k] + 16'd1;
          if (m_next_handle == 0) m_next_handle = 16'd1;
          m_count[k] = cnt;
          m_reload[k] = cnt;
          m_periodic[k] = cw.periodic;
          m_notify[k] = cw.notify;
          m_tag[k] = cw.tag;
          r.new_handle = m_handle[k];
        end
      end
      CMD_UNREG: begin
        r.status = ST_NOT_FOUND;
        if (cw.target != 0) begin
          for (k = 0; k < SLOTS; k++) begin
            if (m_handle[k] == cw.target) begin
              clear_slot(k);
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random stalls, plus one long hold while the sender keeps offering.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    reply_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        report("unexpected word", 64'(out_tdata), 64'd0);
      end else begin
        w = expected_replies.pop_front();
        if (out_tdata[1:0] !== w.status)
          report("status", 64'(out_tdata[1:0]), 64'(w.status));
        if (out_tdata[17:2] !== w.new_handle)
          report("new_handle", 64'(out_tdata[17:2]), 64'(w.new_handle));
        if (out_tdata[18] !== w.fired)
          report("fired", 64'(out_tdata[18]), 64'(w.fired));
        if (out_tdata[50:19] !== w.fired_tag)
          report("fired_tag", 64'(out_tdata[50:19]), 64'(w.fired_tag));
        if (out_tdata[66:51] !== w.fired_handle)
          report("fired_handle", 64'(out_tdata[66:51]), 64'(w.fired_handle));
        if (out_tdata[71:67] !== 5'd0) report("fill", 64'(out_tdata[71:67]), 64'd0);
      end
    end
  end

  task automatic send_word(command_word_t cw, bit known, reply_word_t want);
    reply_word_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cw.cmd;
    in_tdata <= {7'd0, cw.target, cw.tag, cw.notify, cw.periodic, cw.delay};
    do @(posedge clk); while (!in_tready);
    p = timer_table_step(cw);
    if (known && p != want) report("directed row", 64'(p), 64'(want));
    expected_replies.push_back(p);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_base(logic [BASE_W-1:0] v);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    m_base = v;
  endtask

  function automatic command_word_t make_cmd(cmd_t c, logic [DELAY_W-1:0] d, logic per,
                                             logic ntf, logic [TAG_W-1:0] t,
                                             logic [HANDLE_W-1:0] h);
    command_word_t cw;
    cw = '{cmd: c, delay: d, periodic: per, notify: ntf, tag: t, target: h};
    return cw;
  endfunction

  function automatic reply_word_t rep(logic [1:0] s, logic [HANDLE_W-1:0] nh);
    reply_word_t r;
    r = '{default: '0};
    r.status = s;
    r.new_handle = nh;
    return r;
  endfunction

  // Random command with a bias toward live handles so removals hit.
  function automatic command_word_t random_cmd();
    command_word_t cw;
    int pick, k;
    cw.delay = ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(0, 400));
    cw.periodic = 1'($urandom_range(0, 1));
    cw.notify = ($urandom_range(0, 4) != 0);
    cw.tag = $urandom;
    cw.target = HANDLE_W'($urandom);
    pick = $urandom_range(0, 15);
    if (pick < 9) cw.cmd = CMD_TICK;
    else if (pick < 13) cw.cmd = CMD_REG;
    else if (pick < 15) cw.cmd = CMD_UNREG;
    else cw.cmd = CMD_NONE;
    if (cw.cmd == CMD_UNREG && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, SLOTS - 1);
      cw.target = m_handle[k];
    end
    return cw;
  endfunction

  initial begin
    stim_row_t rows[$];
    reply_word_t none;
    int n;
    none = '{default: '0};
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back('{make_cmd(CMD_TICK, 0, 0, 0, 0, 0), 1, none});
    rows.push_back('{make_cmd(CMD_UNREG, 0, 0, 0, 0, 0), 1, rep(ST_NOT_FOUND, 0)});
    rows.push_back('{make_cmd(CMD_UNREG, 0, 0, 0, 0, 16'hffff), 1, rep(ST_NOT_FOUND, 0)});
    rows.push_back('{make_cmd(CMD_NONE, '1, 1, 1, '1, '1), 1, none});
    rows.push_back('{make_cmd(CMD_REG, 0, 0, 1, 32'h0000_0000, 0), 1, rep(ST_OK, 1)});
    rows.push_back('{make_cmd(CMD_REG, '1, 1, 1, 32'hffff_ffff, 16'hffff), 1, rep(ST_OK, 2)});
    rows.push_back('{make_cmd(CMD_REG, 16, 1, 1, 32'hdead_beef, 0), 0, none});
    rows.push_back('{make_cmd(CMD_REG, 15, 0, 1, 32'h1234_5678, 0), 0, none});
    rows.push_back('{make_cmd(CMD_REG, 25, 0, 0, 32'h5555_aaaa, 0), 0, none});
    for (int i = 0; i < 4; i++) rows.push_back('{make_cmd(CMD_TICK, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{make_cmd(CMD_UNREG, 0, 0, 0, 0, 16'd2), 1, rep(ST_OK, 0)});
    rows.push_back('{make_cmd(CMD_UNREG, 0, 0, 0, 0, 16'd2), 1, rep(ST_NOT_FOUND, 0)});
    foreach (rows[i]) send_word(rows[i].cw, rows[i].known, rows[i].want);

    // Fill the table to full, then pull everything back out.
    for (int i = 0; i < SLOTS + 2; i++)
      send_word(make_cmd(CMD_REG, DELAY_W'(i * 7), i[0], i[1], $urandom, 0), 0, none);
    for (int i = 0; i < SLOTS; i++)
      send_word(make_cmd(CMD_UNREG, 0, 0, 0, 0, m_handle[i]), 0, none);

    // Odd and extreme time bases, random traffic under each.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_base(20'd0);
        1: write_base(20'd3);
        2: write_base(20'hfffff);
        3: write_base(20'd37);
        4: write_base(BASE_W'($urandom_range(10, 1000)));
        default: write_base(20'd10);
      endcase
      n = (phase == 5) ? 110 : 30;
      if (phase == 5) quiet = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (phase == 1 && i == 10) long_hold = 1'b1;
        if (phase == 3 && i == 25) drain();
        send_word(random_cmd(), 0, none);
      end
    end

    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

### files.f
hw/rtl/mctt_pkg.sv
hw/rtl/mctt_ram.sv
hw/rtl/multi_channel_tick_timer_table.sv
hw/rtl/mctt_chk.sv
tb/sv/multi_channel_tick_timer_table_test.sv
